/* design/pwhd_pkg.sv */
// ----------------------------------------------------------------------------
// pwhd_pkg
// shared widths, register map, reset values and control/status types of the
// packet window hash dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package pwhd_pkg;

  // field widths
  localparam int ByteW   = 8;
  localparam int PortW   = 8;
  localparam int OffsetW = 14;
  localparam int LengthW = 15;
  localparam int CountW  = 9;
  localparam int EndW    = 16;
  localparam int SumW    = 22;

  // remainder unit: one dividend bit per step
  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps);

  // default packet length bound
  localparam int MaxPacketBytesDef = 16384;

  // configuration port
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  localparam logic [1:0] RegWindowOffset = 2'd0;
  localparam logic [1:0] RegWindowLength = 2'd1;
  localparam logic [1:0] RegPortCount    = 2'd2;

  localparam logic [OffsetW-1:0] OffsetReset = OffsetW'(0);
  localparam logic [LengthW-1:0] LengthReset = LengthW'(1);
  localparam logic [CountW-1:0]  CountReset  = CountW'(2);

  // port counts served by the xor fold
  localparam logic [CountW-1:0] PortsTwo   = CountW'(2);
  localparam logic [CountW-1:0] PortsFour  = CountW'(4);
  localparam logic [CountW-1:0] PortsEight = CountW'(8);

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef struct packed {
    logic acc_en;     // take one byte
    logic last;       // byte ends the packet
    logic div_start;  // load the remainder unit
    logic div_step;   // one remainder step
    logic out_load;   // load the output word
  } cmd_t;

  typedef struct packed {
    logic fast;       // port known without the remainder unit
    logic div_last;   // final remainder step in progress
  } status_t;

endpackage

`default_nettype wire

/* design/pwhd_datapath.sv */
// ----------------------------------------------------------------------------
// pwhd_datapath
// byte counter, window sum, held packet result, serial remainder unit and
// output word register
// ----------------------------------------------------------------------------
`default_nettype none

module pwhd_datapath #(
  parameter int MAX_PACKET_BYTES = pwhd_pkg::MaxPacketBytesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pwhd_pkg::cmd_t               cmd_i,
  output pwhd_pkg::status_t                 status_o,
  input  wire logic [pwhd_pkg::ByteW-1:0]   data_byte_i,
  input  wire logic [pwhd_pkg::OffsetW-1:0] window_offset_i,
  input  wire logic [pwhd_pkg::LengthW-1:0] window_length_i,
  input  wire logic [pwhd_pkg::CountW-1:0]  port_count_i,
  output logic      [pwhd_pkg::PortW-1:0]   out_port_o
);

  localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CmpW = (PosW > pwhd_pkg::EndW) ? PosW : pwhd_pkg::EndW;

  logic [PosW-1:0]              pos_q, pos_d, pos_next;
  logic [pwhd_pkg::SumW-1:0]    sum_q, sum_d, sum_next;
  logic [PosW-1:0]              len_hold_q, len_hold_d;
  logic [pwhd_pkg::SumW-1:0]    sum_hold_q, sum_hold_d;
  logic [pwhd_pkg::CountW-1:0]  rem_q, rem_d;
  logic [pwhd_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [pwhd_pkg::PortW-1:0]   out_port_q, out_port_d;

  logic [pwhd_pkg::EndW-1:0]    win_end;
  logic [CmpW-1:0]              pos_ext;
  logic                         in_range;
  logic                         in_window;
  logic [pwhd_pkg::SumW:0]      sum_add;
  logic                         is_short;
  logic                         is_fold;
  logic [pwhd_pkg::PortW-1:0]   fold_val;
  logic [pwhd_pkg::PortW-1:0]   fast_val;
  logic [pwhd_pkg::CountW:0]    trial;

  // window bounds, config must stay static while bytes flow (not enforced here)
  assign win_end   = pwhd_pkg::EndW'(window_offset_i) + pwhd_pkg::EndW'(window_length_i);
  assign pos_ext   = CmpW'(pos_q);
  assign in_range  = pos_q < PosW'(MAX_PACKET_BYTES);
  assign in_window = in_range && (pos_ext >= CmpW'(window_offset_i))
                     && (pos_ext < CmpW'(win_end));

  // saturating sum and counter
  assign sum_add  = {1'b0, sum_q} + (pwhd_pkg::SumW + 1)'(data_byte_i);
  assign sum_next = !in_window ? sum_q
                  : (sum_add[pwhd_pkg::SumW] ? pwhd_pkg::SumMax : sum_add[pwhd_pkg::SumW-1:0]);
  assign pos_next = in_range ? pos_q + PosW'(1) : pos_q;

  // port selection from the held packet
  assign is_short = CmpW'(len_hold_q) < CmpW'(win_end);
  assign is_fold  = (port_count_i == pwhd_pkg::PortsTwo) ||
                    (port_count_i == pwhd_pkg::PortsFour) ||
                    (port_count_i == pwhd_pkg::PortsEight);
  assign fold_val = (sum_hold_q[7:0] ^ sum_hold_q[11:4])
                    & pwhd_pkg::PortW'(port_count_i - pwhd_pkg::CountW'(1));
  assign fast_val = (is_short || !is_fold) ? '0 : fold_val;

  assign status_o.fast     = is_short || is_fold || (port_count_i == '0);
  assign status_o.div_last = cnt_q == pwhd_pkg::DivCntW'(pwhd_pkg::DivSteps - 1);

  // restoring remainder step, msb of the held sum first
  assign trial = {rem_q, sum_hold_q[pwhd_pkg::SumW-1]};

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    len_hold_d = len_hold_q;
    sum_hold_d = sum_hold_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    out_port_d = out_port_q;
    if (cmd_i.acc_en) begin
      if (cmd_i.last) begin
        pos_d      = '0;
        sum_d      = '0;
        len_hold_d = pos_next;
        sum_hold_d = sum_next;
      end else begin
        pos_d = pos_next;
        sum_d = sum_next;
      end
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, port_count_i}) begin
        rem_d = pwhd_pkg::CountW'(trial - {1'b0, port_count_i});
      end else begin
        rem_d = trial[pwhd_pkg::CountW-1:0];
      end
      sum_hold_d = {sum_hold_q[pwhd_pkg::SumW-2:0], 1'b0};
      cnt_d      = cnt_q + pwhd_pkg::DivCntW'(1);
    end
    if (cmd_i.out_load) begin
      out_port_d = status_o.fast ? fast_val : rem_q[pwhd_pkg::PortW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_hold_q <= len_hold_d;
    sum_hold_q <= sum_hold_d;
    rem_q      <= rem_d;
    out_port_q <= out_port_d;
  end

  assign out_port_o = out_port_q;

endmodule

`default_nettype wire

/* design/pwhd_ctrl.sv */
// ----------------------------------------------------------------------------
// pwhd_ctrl
// sequencer for byte intake, port selection, remainder steps and the output
// word handshake
// ----------------------------------------------------------------------------
`default_nettype none

module pwhd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire logic              s_tlast_i,
  output logic                   s_tready_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  input  wire pwhd_pkg::status_t status_i,
  output pwhd_pkg::cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SEL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   m_tvalid_q, m_tvalid_d;
  logic   out_free;

  assign out_free   = !m_tvalid_q || m_tready_i;
  assign s_tready_o = state_q == ST_RUN;
  assign m_tvalid_o = m_tvalid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.acc_en    = s_tvalid_i && (state_q == ST_RUN);
    cmd_o.last      = s_tlast_i;
    cmd_o.div_start = (state_q == ST_SEL) && !status_i.fast;
    cmd_o.div_step  = state_q == ST_DIV;
    cmd_o.out_load  = (state_q == ST_OUT) && out_free;
  end

  always_comb begin
    state_d    = state_q;
    m_tvalid_d = m_tvalid_q;
    if (m_tready_i) begin
      m_tvalid_d = 1'b0;
    end
    unique case (state_q)
      ST_RUN: begin
        if (cmd_o.acc_en && s_tlast_i) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        state_d = status_i.fast ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  // final byte always leads to port selection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.acc_en && cmd_o.last) |=> (state_q == ST_SEL))
    else $error("final byte did not start port selection");

  // a held word is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!m_tvalid_q || m_tready_i))
    else $error("output word overwritten while stalled");

  // remainder unit runs until its final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !status_i.div_last) |=> (state_q == ST_DIV))
    else $error("remainder unit left early");

  // no intake while a packet result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEL || state_q == ST_DIV) |-> !cmd_o.acc_en)
    else $error("byte taken during port selection");

endmodule

`default_nettype wire

/* design/packet_window_hash_dispatch.sv */
// ----------------------------------------------------------------------------
// packet_window_hash_dispatch
// per-packet output port selection from a hashed byte window
// ----------------------------------------------------------------------------
// packets enter one byte per word on the s_axis channel, tlast on the final
// byte. bytes whose position lies in [window_offset, window_offset +
// window_length) are summed (saturating, 22 bits); positions count up to
// MAX_PACKET_BYTES and stop there. on the final byte one word leaves on the
// m_axis channel carrying the chosen port.
// throughput: one byte per cycle inside a packet. after the final byte the
// input is held off while the port is worked out: directly when the packet
// is short or the port count is 0, 2, 4 or 8, else by the serial remainder
// unit that retires one of the 22 sum bits per cycle.
// the output word sits in its own register, so the next packet is taken while
// a result waits; a stalled m_axis_tready only holds the input off when a
// second result is ready to leave before the first is taken.
// configuration goes through the apb port (offset at 0x0, length at 0x4,
// port count at 0x8), to be written only between packets; not enforced.
// reset clears the counters, the handshakes and the registers to offset 0,
// length 1, port count 2.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_window_hash_dispatch #(
  parameter int MAX_PACKET_BYTES = pwhd_pkg::MaxPacketBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // byte input
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [pwhd_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  wire logic                          s_axis_tlast,   // last_byte
  // port output
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [pwhd_pkg::PortW-1:0]    m_axis_tdata,   // [7:0] out_port
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pwhd_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [pwhd_pkg::ApbDataW-1:0] pwdata,
  output logic      [pwhd_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);

  logic [pwhd_pkg::OffsetW-1:0] window_offset_q, window_offset_d;
  logic [pwhd_pkg::LengthW-1:0] window_length_q, window_length_d;
  logic [pwhd_pkg::CountW-1:0]  port_count_q, port_count_d;
  logic [1:0]                   reg_idx;
  logic                         wr_en;

  pwhd_pkg::cmd_t    cmd;
  pwhd_pkg::status_t status;

  // register file, writes keep the low bits only
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    window_offset_d = window_offset_q;
    window_length_d = window_length_q;
    port_count_d    = port_count_q;
    if (wr_en) begin
      unique case (reg_idx)
        pwhd_pkg::RegWindowOffset: window_offset_d = pwdata[pwhd_pkg::OffsetW-1:0];
        pwhd_pkg::RegWindowLength: window_length_d = pwdata[pwhd_pkg::LengthW-1:0];
        pwhd_pkg::RegPortCount:    port_count_d    = pwdata[pwhd_pkg::CountW-1:0];
        default: ; // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pwhd_pkg::RegWindowOffset: prdata = pwhd_pkg::ApbDataW'(window_offset_q);
      pwhd_pkg::RegWindowLength: prdata = pwhd_pkg::ApbDataW'(window_length_q);
      pwhd_pkg::RegPortCount:    prdata = pwhd_pkg::ApbDataW'(port_count_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_offset_q <= pwhd_pkg::OffsetReset;
      window_length_q <= pwhd_pkg::LengthReset;
      port_count_q    <= pwhd_pkg::CountReset;
    end else begin
      window_offset_q <= window_offset_d;
      window_length_q <= window_length_d;
      port_count_q    <= port_count_d;
    end
  end

  // sequencer
  pwhd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, window sum, remainder unit and output word
  pwhd_datapath #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .data_byte_i     (s_axis_tdata),
    .window_offset_i (window_offset_q),
    .window_length_i (window_length_q),
    .port_count_i    (port_count_q),
    .out_port_o      (m_axis_tdata)
  );

endmodule

`default_nettype wire
